FILE: hw/rtl/mime_header_line_unfolder_defines.svh
// Assertion macros for the header line unfolder.
`ifndef MIME_HEADER_LINE_UNFOLDER_DEFINES_SVH
`define MIME_HEADER_LINE_UNFOLDER_DEFINES_SVH

`ifndef SYNTH
`define MHU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MHU_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MHU_ASSERT(lbl, clk, rst_n, prop, msg)
`define MHU_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/mhu_pkg.sv
// Types and constants of the header line unfolder.
package mhu_pkg;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;
  localparam logic [1:0] KIND_REFUSED  = 2'd3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    MODE_PARSING = 3'd0,
    MODE_GOTCR   = 3'd1,
    MODE_UNSURE  = 3'd2,
    MODE_SKIP    = 3'd3,
    MODE_DONE    = 3'd4
  } parse_mode_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] line_byte;
    logic       consumed;
    logic       last;
  } out_item_t;

endpackage

FILE: hw/rtl/mime_header_line_unfolder.sv
// Header line unfolder: byte state machine with a four-entry result queue.
// Results are written into the result queue when their input item is accepted; out_ shows the queue head.
// Throughput: one item per cycle; in_stall rises while more than two results
// wait in the result queue, so two-result items briefly hold off the input.
// Reset (rst_n low, synchronous): parsing an empty line, result queue empty.
`include "mime_header_line_unfolder_defines.svh"
module mime_header_line_unfolder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mhu_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mhu_pkg::out_item_t out_item
);
  import mhu_pkg::*;

  parse_mode_t mode_r, mode_nxt;
  logic        lhb_r, lhb_nxt;

  out_item_t         fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r, count_nxt;

  logic       accept, pop;
  logic [7:0] ch;
  logic       lhb_in, do_in;
  logic [1:0] n;
  out_item_t  res [2];

  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = count_r > (FIFO_AW+1)'(FIFO_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_item  = fifo_mem[rd_ptr_r];

  // tab counts as space
  assign ch = (in_item.byte_value == CH_TAB) ? CH_SP : in_item.byte_value;

  always_comb begin
    mode_nxt = mode_r;
    lhb_nxt  = lhb_r;
    lhb_in   = lhb_r;
    do_in    = 1'b0;
    n        = 2'd0;
    res[0]   = '0;
    res[1]   = '0;
    if (in_item.operation == OP_RESTART) begin
      mode_nxt = MODE_PARSING;
      lhb_nxt  = 1'b0;
    end else begin
      case (mode_r)
        MODE_GOTCR: begin
          if (ch == CH_LF) begin
            if (!lhb_r) begin
              mode_nxt = MODE_DONE;
              res[0]   = '{kind: KIND_END, line_byte: 8'h00, consumed: 1'b1, last: 1'b0};
              n        = 2'd1;
            end else begin
              mode_nxt = MODE_UNSURE;
            end
          end else if (!lhb_r) begin
            // byte belongs to the body
            mode_nxt = MODE_DONE;
            res[0]   = '{kind: KIND_END, line_byte: 8'h00, consumed: 1'b0, last: 1'b0};
            n        = 2'd1;
          end else if (ch == CH_SP) begin
            mode_nxt = MODE_SKIP;
          end else begin
            res[0]  = '{kind: KIND_COMPLETE, line_byte: 8'h00, consumed: 1'b1, last: 1'b0};
            n       = 2'd1;
            lhb_nxt = 1'b0;
            lhb_in  = 1'b0;
            do_in   = 1'b1;
          end
        end
        MODE_UNSURE: begin
          if (ch == CH_SP) begin
            mode_nxt = MODE_SKIP;
          end else begin
            res[0]  = '{kind: KIND_COMPLETE, line_byte: 8'h00, consumed: 1'b1, last: 1'b0};
            n       = 2'd1;
            lhb_nxt = 1'b0;
            lhb_in  = 1'b0;
            do_in   = 1'b1;
          end
        end
        MODE_SKIP: begin
          do_in = (ch != CH_SP);
        end
        MODE_DONE: begin
          res[0] = '{kind: KIND_REFUSED, line_byte: 8'h00, consumed: 1'b0, last: 1'b0};
          n      = 2'd1;
        end
        default: begin
          do_in = 1'b1;
        end
      endcase

      // handle the byte as part of a line
      if (do_in) begin
        mode_nxt = MODE_PARSING;
        if (ch == CH_CR) begin
          mode_nxt = MODE_GOTCR;
        end else if (ch == CH_LF) begin
          if (!lhb_in) begin
            mode_nxt = MODE_DONE;
            res[n[0]] = '{kind: KIND_END, line_byte: 8'h00, consumed: 1'b1, last: 1'b0};
            n = n + 2'd1;
          end else begin
            mode_nxt = MODE_UNSURE;
          end
        end else begin
          lhb_nxt = 1'b1;
          res[n[0]] = '{kind: KIND_BYTE, line_byte: ch, consumed: 1'b1, last: 1'b0};
          n = n + 2'd1;
        end
      end
    end

    // mark the final result of this item
    if (n == 2'd2) begin
      res[1].last = 1'b1;
    end else if (n == 2'd1) begin
      res[0].last = 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = count_nxt + (FIFO_AW+1)'(n);
    end
    if (pop) begin
      count_nxt = count_nxt - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_PARSING;
      lhb_r    <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (accept) begin
        mode_r   <= mode_nxt;
        lhb_r    <= lhb_nxt;
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(n);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n != 2'd0) begin
      fifo_mem[wr_ptr_r] <= res[0];
    end
    if (accept && n == 2'd2) begin
      fifo_mem[wr_ptr_r + FIFO_AW'(1)] <= res[1];
    end
  end

  `MHU_ASSERT(a_count_bound, clk, rst_n, count_r <= (FIFO_AW+1)'(FIFO_DEPTH), "result queue overflow")
  `MHU_ASSERT(a_done_holds, clk, rst_n, (accept && in_item.operation == OP_BYTE && mode_r == MODE_DONE) |=> (mode_r == MODE_DONE), "left done mode without restart")
  `MHU_ASSERT(a_wait_nonempty, clk, rst_n, (mode_r == MODE_UNSURE || mode_r == MODE_SKIP) |-> lhb_r, "pending line end on an empty line")
  `MHU_ASSERT(a_pair_order, clk, rst_n, (accept && n == 2'd2) |-> (res[0].kind == KIND_COMPLETE && res[1].last), "two results not led by line complete")
  `MHU_ASSERT(a_queue_flag, clk, rst_n, (accept && n != 2'd0 && !pop) |=> out_valid, "queued result not shown")

endmodule
